// ----- design/fwms_pkg.sv -----
`timescale 1ns / 1ps

package fwms_pkg;

    localparam int OP_W       = 2;
    localparam int ST_W       = 2;
    localparam int KEY_PORT_W = 64;

    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ----- design/fifo_with_membership_search_top.sv -----
`timescale 1ns / 1ps

// Bounded FIFO of keys with a membership search.
// A transaction is accepted at a rising edge where start is high and busy is low.
// The operation on i_op is put, get, search or clear, and i_key carries the key.
// Only the low KEY_BITS bits of the key are stored and compared.
// Each transaction produces exactly one result, shown for one cycle with o_done high.
// The receiver cannot stall, so every result must be taken in the cycle it appears.
// Put, clear, a put on a full queue and a get on an empty queue give their result
// in the cycle after acceptance, and busy stays low.
// A successful get reads the entry memory, passes through state S_GET and gives its
// result from the done register, with busy high for one cycle.
// A search reads one stored entry per cycle through the single read port of the
// entry memory and compares it with the key, oldest entry first.
// It finishes at the first match or after all entries are compared.
// Reset empties the queue. The stored keys themselves are not cleared.
module fifo_with_membership_search_top #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 64,
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [fwms_pkg::OP_W-1:0]          i_op,
    input  logic [fwms_pkg::KEY_PORT_W-1:0]    i_key,
    output logic                               o_done,
    output logic [fwms_pkg::ST_W-1:0]          o_status,
    output logic                               o_found,
    output logic [fwms_pkg::KEY_PORT_W-1:0]    o_key_out,
    output logic [CNT_W-1:0]                   o_item_count,
    output logic                               o_is_empty_flag
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GET  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    localparam int SUM_W = $clog2(2 * DEPTH) + 1;

    logic [KEY_BITS-1:0] r_mem [DEPTH];
    logic [KEY_BITS-1:0] r_rd_data;

    logic [1:0]                  r_state, n_state;
    logic [PTR_W-1:0]            r_head, n_head;
    logic [PTR_W-1:0]            r_tail, n_tail;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [PTR_W-1:0]            r_ptr, n_ptr;
    logic [CNT_W-1:0]            r_left, n_left;
    logic                        r_pend, n_pend;
    logic                        r_done, n_done;
    logic [KEY_BITS-1:0]         r_key, n_key;
    logic [fwms_pkg::ST_W-1:0]   r_status, n_status;
    logic                        r_found, n_found;
    logic [KEY_BITS-1:0]         r_key_out, n_key_out;

    logic                        w_accept;
    logic                        w_we;
    logic [PTR_W-1:0]            w_raddr;
    logic [PTR_W-1:0]            w_head_nx;
    logic [PTR_W-1:0]            w_tail_nx;
    logic [PTR_W-1:0]            w_ptr_nx;
    logic [SUM_W-1:0]            w_sum;
    logic [PTR_W-1:0]            w_tail_exp;

    assign w_accept  = start && !busy;
    assign w_head_nx = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
    assign w_tail_nx = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
    assign w_ptr_nx  = (r_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_ptr + PTR_W'(1);
    assign w_raddr   = (r_state == S_IDLE) ? r_head : r_ptr;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_pend    = r_pend;
        n_key     = r_key;
        n_done    = 1'b0;
        n_status  = fwms_pkg::ST_OK;
        n_found   = 1'b0;
        n_key_out = '0;
        w_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key = i_key[KEY_BITS-1:0];
                    case (i_op)
                        fwms_pkg::OP_PUT: begin
                            n_done = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = fwms_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_tail  = w_tail_nx;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        fwms_pkg::OP_GET: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = fwms_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_GET;
                            end
                        end
                        fwms_pkg::OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_SRCH;
                                n_ptr   = r_head;
                                n_left  = r_count;
                                n_pend  = 1'b0;
                            end
                        end
                        fwms_pkg::OP_CLEAR: begin
                            n_done  = 1'b1;
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_GET: begin
                n_done    = 1'b1;
                n_key_out = r_rd_data;
                n_head    = w_head_nx;
                n_count   = r_count - CNT_W'(1);
                n_state   = S_IDLE;
            end
            S_SRCH: begin
                if (r_pend && (r_rd_data == r_key)) begin
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_state = S_IDLE;
                end else if (r_left == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_ptr  = w_ptr_nx;
                    n_left = r_left - CNT_W'(1);
                    n_pend = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_ptr   <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_left  <= n_left;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_status  <= n_status;
        r_found   <= n_found;
        r_key_out <= n_key_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_tail] <= n_key;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_comb begin
        o_key_out                = '0;
        o_key_out[KEY_BITS-1:0]  = r_key_out;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_found         = r_found;
    assign o_item_count    = r_count;
    assign o_is_empty_flag = (r_count == '0);

    always_comb begin
        w_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (w_sum >= SUM_W'(DEPTH)) begin
            w_tail_exp = PTR_W'(w_sum - SUM_W'(DEPTH));
        end else begin
            w_tail_exp = PTR_W'(w_sum);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_tail_exp == r_tail))
        else $error("Tail pointer disagrees with head pointer plus count.");

    a_fast_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == fwms_pkg::OP_PUT || i_op == fwms_pkg::OP_CLEAR)) |=> o_done)
        else $error("Put or clear did not respond in the next cycle.");

    a_found_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> (o_done && o_status == fwms_pkg::ST_OK))
        else $error("Found flag raised outside a search result.");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == fwms_pkg::ST_FULL) |-> (r_count == CNT_W'(DEPTH)))
        else $error("Full status reported while the queue has room.");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 64;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 950;
    localparam int POOL_SIZE    = 24;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam logic [fwms_pkg::KEY_PORT_W-1:0] KEY_MASK =
        {fwms_pkg::KEY_PORT_W{1'b1}} >> (fwms_pkg::KEY_PORT_W - KEY_BITS);

    typedef struct packed {
        logic [fwms_pkg::OP_W-1:0]       op;
        logic [fwms_pkg::KEY_PORT_W-1:0] key;
    } t_fifo_cmd;

    typedef struct packed {
        logic [fwms_pkg::ST_W-1:0]       status;
        logic                            found;
        logic [fwms_pkg::KEY_PORT_W-1:0] key_out;
        logic [CNT_W-1:0]                count;
        logic                            empty;
    } t_fifo_resp;

    logic                            i_clk   = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start   = 1'b0;
    logic [fwms_pkg::OP_W-1:0]       i_op    = fwms_pkg::OP_PUT;
    logic [fwms_pkg::KEY_PORT_W-1:0] i_key   = '0;
    logic                            busy;
    logic                            o_done;
    logic [fwms_pkg::ST_W-1:0]       o_status;
    logic                            o_found;
    logic [fwms_pkg::KEY_PORT_W-1:0] o_key_out;
    logic [CNT_W-1:0]                o_item_count;
    logic                            o_is_empty_flag;

    t_fifo_cmd  pending_cmds [$];
    t_fifo_resp expected_resp [$];

    logic [fwms_pkg::KEY_PORT_W-1:0] model_slots [DEPTH];
    int unsigned                     model_head  = 0;
    int unsigned                     model_tail  = 0;
    int unsigned                     model_count = 0;

    logic [fwms_pkg::KEY_PORT_W-1:0] key_pool [POOL_SIZE];

    logic took        = 1'b0;
    int   gap_left    = 0;
    logic no_idle     = 1'b0;
    int   cycle_count = 0;
    int   error_count = 0;

    fifo_with_membership_search_top #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_key           (i_key),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_key_out       (o_key_out),
        .o_item_count    (o_item_count),
        .o_is_empty_flag (o_is_empty_flag)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_fifo_resp predict_fifo(input t_fifo_cmd cmd);
        t_fifo_resp                      r;
        logic [fwms_pkg::KEY_PORT_W-1:0] k;
        int unsigned                     slot;
        int unsigned                     n;
        r        = '0;
        r.status = fwms_pkg::ST_OK;
        k        = cmd.key & KEY_MASK;
        case (cmd.op)
            fwms_pkg::OP_PUT: begin
                if (model_count >= DEPTH) begin
                    r.status = fwms_pkg::ST_FULL;
                end else begin
                    model_slots[model_tail] = k;
                    model_tail  = (model_tail + 1) % DEPTH;
                    model_count = model_count + 1;
                end
            end
            fwms_pkg::OP_GET: begin
                if (model_count == 0) begin
                    r.status = fwms_pkg::ST_EMPTY;
                end else begin
                    r.key_out   = model_slots[model_head];
                    model_head  = (model_head + 1) % DEPTH;
                    model_count = model_count - 1;
                end
            end
            fwms_pkg::OP_SEARCH: begin
                slot = model_head;
                for (n = 0; n < model_count; n++) begin
                    if (model_slots[slot] == k) begin
                        r.found = 1'b1;
                    end
                    slot = (slot + 1) % DEPTH;
                end
            end
            fwms_pkg::OP_CLEAR: begin
                model_head  = 0;
                model_tail  = 0;
                model_count = 0;
            end
            default: begin
            end
        endcase
        r.count = model_count[CNT_W-1:0];
        r.empty = (model_count == 0);
        return r;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    function automatic string show_resp(input t_fifo_resp r);
        return $sformatf("status=%0d found=%0d key_out=%h count=%0d empty=%0d",
                         r.status, r.found, r.key_out, r.count, r.empty);
    endfunction

    always @(posedge i_clk) begin
        t_fifo_resp got;
        t_fifo_resp want;
        t_fifo_cmd  cmd;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fifo_with_membership_search_top test failed");
            $finish;
        end else begin
            took = 1'b0;
            if (i_rst_n) begin
                if (o_done === 1'b1) begin
                    got.status  = o_status;
                    got.found   = o_found;
                    got.key_out = o_key_out;
                    got.count   = o_item_count;
                    got.empty   = o_is_empty_flag;
                    if (expected_resp.size() == 0) begin
                        flag_error($sformatf("cycle %0d: unexpected result %s",
                                             cycle_count, show_resp(got)));
                    end else begin
                        want = expected_resp.pop_front();
                        if (got !== want) begin
                            flag_error($sformatf("cycle %0d: expected %s, got %s",
                                                 cycle_count, show_resp(want),
                                                 show_resp(got)));
                        end
                    end
                end
                if (start === 1'b1 && busy === 1'b0) begin
                    took    = 1'b1;
                    cmd.op  = i_op;
                    cmd.key = i_key;
                    expected_resp.push_back(predict_fifo(cmd));
                end
            end
        end
    end

    always @(negedge i_clk) begin
        t_fifo_cmd next_cmd;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took) begin
            // Hold the transaction until the block accepts it.
        end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left = gap_left - 1;
        end else if (pending_cmds.size() > 0) begin
            next_cmd = pending_cmds.pop_front();
            start    <= 1'b1;
            i_op     <= next_cmd.op;
            i_key    <= next_cmd.key;
            if ($urandom_range(0, 39) == 0) begin
                no_idle = !no_idle;
            end
            gap_left = no_idle ? 0 : $urandom_range(0, 5);
        end else begin
            start <= 1'b0;
        end
    end

    task automatic add_cmd(input logic [fwms_pkg::OP_W-1:0] op,
                           input logic [fwms_pkg::KEY_PORT_W-1:0] key);
        t_fifo_cmd c;
        c.op  = op;
        c.key = key;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [fwms_pkg::OP_W-1:0] choose_op(input int put_pct,
                                                            input int get_pct,
                                                            input int search_pct);
        int pct;
        pct = $urandom_range(0, 99);
        if (pct < put_pct) begin
            return fwms_pkg::OP_PUT;
        end else if (pct < put_pct + get_pct) begin
            return fwms_pkg::OP_GET;
        end else if (pct < put_pct + get_pct + search_pct) begin
            return fwms_pkg::OP_SEARCH;
        end
        return fwms_pkg::OP_CLEAR;
    endfunction

    initial begin
        int                              n;
        int                              mode;
        int                              seg_left;
        logic [fwms_pkg::OP_W-1:0]       op;
        logic [fwms_pkg::KEY_PORT_W-1:0] key;
        logic [fwms_pkg::KEY_PORT_W-1:0] last_put;

        for (n = 0; n < POOL_SIZE; n++) begin
            key_pool[n] = {$urandom, $urandom};
        end
        key_pool[0] = '0;
        key_pool[1] = '1;

        add_cmd(fwms_pkg::OP_GET, '0);
        add_cmd(fwms_pkg::OP_SEARCH, '0);
        add_cmd(fwms_pkg::OP_PUT, '1);
        add_cmd(fwms_pkg::OP_PUT, '0);
        add_cmd(fwms_pkg::OP_PUT, {16{4'hA}});
        add_cmd(fwms_pkg::OP_PUT, {16{4'h5}});
        for (n = 0; n < DEPTH - 4; n++) begin
            last_put = key_pool[2 + n];
            add_cmd(fwms_pkg::OP_PUT, last_put);
        end
        add_cmd(fwms_pkg::OP_PUT, {$urandom, $urandom});
        add_cmd(fwms_pkg::OP_SEARCH, '1);
        add_cmd(fwms_pkg::OP_SEARCH, last_put);
        add_cmd(fwms_pkg::OP_SEARCH, 64'h0123_4567_89ab_cdef);
        add_cmd(fwms_pkg::OP_GET, '0);
        add_cmd(fwms_pkg::OP_CLEAR, '1);
        add_cmd(fwms_pkg::OP_GET, '0);
        add_cmd(fwms_pkg::OP_SEARCH, '0);

        seg_left = 0;
        mode     = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(8, 40);
            end
            seg_left--;
            case (mode)
                0:       op = choose_op(70, 13, 15);
                1:       op = choose_op(13, 70, 15);
                2:       op = choose_op(30, 20, 48);
                default: op = choose_op(35, 30, 33);
            endcase
            if ($urandom_range(0, 3) == 0) begin
                key = {$urandom, $urandom};
            end else begin
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            add_cmd(op, key);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (pending_cmds.size() != 0 || start || expected_resp.size() != 0);
        repeat (DEPTH + 4) @(negedge i_clk);

        if (error_count == 0 && expected_resp.size() == 0) begin
            $display("fifo_with_membership_search_top test passed");
        end else begin
            $display("fifo_with_membership_search_top test failed");
        end
        $finish;
    end

endmodule

// ----- fifo_with_membership_search_top.f -----
design/fwms_pkg.sv
design/fifo_with_membership_search_top.sv
tb/tb.sv
